// File: hdl/mctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants for the tick timer bank: operation codes,
// channel modes, result kinds, state entry, memory request and result layouts.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int ADDRESSABLE      = 8;
  localparam int CH_FIELD_W       = 3;
  localparam int COUNT_W          = 16;
  localparam int BYTE_W           = 8;

  typedef enum logic [2:0] {
    OP_TICK            = 3'd0,
    OP_START_WAKE      = 3'd1,
    OP_START_PERIODIC  = 3'd2,
    OP_START_COUNTDOWN = 3'd3,
    OP_STOP            = 3'd4,
    OP_PAUSE           = 3'd5,
    OP_RESUME          = 3'd6,
    OP_CHECK           = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_WAKE      = 2'd1,
    MODE_PERIODIC  = 2'd2,
    MODE_COUNTDOWN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SIGNAL = 2'd0,
    KIND_WAKE   = 2'd1,
    KIND_REPLY  = 2'd2
  } kind_t;

  typedef struct packed {
    mode_t               mode;
    logic [COUNT_W-1:0]  count;
    logic                pause;
    logic [BYTE_W-1:0]   period;
    logic [BYTE_W-1:0]   target;
  } entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [CH_FIELD_W-1:0] rd_addr;
    logic                  wr_en;
    logic [CH_FIELD_W-1:0] wr_addr;
    entry_t                wr_data;
  } mem_req_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CH_FIELD_W-1:0] channel;
    logic [BYTE_W-1:0]     target;
    logic [COUNT_W-1:0]    remaining;
    logic                  last;
  } result_t;

endpackage

// File: hdl/mctt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_in_if / mctt_out_if
// Valid/ready channels for commands into and results out of the timer bank.
// ----------------------------------------------------------------------------
interface mctt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [2:0]  channel;
  logic [15:0] start_count;
  logic [7:0]  target_id;

  modport source (output valid, output op, output channel, output start_count,
                  output target_id, input ready);
  modport sink   (input valid, input op, input channel, input start_count,
                  input target_id, output ready);
endinterface

interface mctt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  out_channel;
  logic [7:0]  out_target;
  logic [15:0] remaining;
  logic        last;

  modport source (output valid, output kind, output out_channel, output out_target,
                  output remaining, output last, input ready);
  modport sink   (input valid, input kind, input out_channel, input out_target,
                  input remaining, input last, output ready);
endinterface

// File: hdl/mctt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_mem
// Channel state memory, one read and one write port, registered read data.
// Per-entry valid bits make unwritten entries read as the reset state.
// ----------------------------------------------------------------------------
module mctt_mem #(
  parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mctt_pkg::mem_req_t req,
  output mctt_pkg::entry_t   rd_data
);
  import mctt_pkg::*;

  localparam int LIVE      = (NUM_CHANNELS < ADDRESSABLE) ? NUM_CHANNELS : ADDRESSABLE;
  localparam int CH_W      = (LIVE > 1) ? $clog2(LIVE) : 1;
  localparam int MEM_DEPTH = 1 << CH_W;

  entry_t                 mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]   valid_r;
  entry_t                 rd_data_r;
  logic [CH_W-1:0]        rd_idx;
  logic [CH_W-1:0]        wr_idx;

  assign rd_idx  = req.rd_addr[CH_W-1:0];
  assign wr_idx  = req.wr_addr[CH_W-1:0];
  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[wr_idx] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[rd_idx] ? mem_r[rd_idx] : '0;
    end
  end

endmodule

// File: hdl/mctt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_seq
// Command sequencer: read-modify-write of channel entries, tick sweep over the
// channels one per cycle unless an event waits on a full result register, and result
// generation with a held-back event so the final event of a tick carries the last flag.
// ----------------------------------------------------------------------------
module mctt_seq #(
  parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  mctt_in_if.sink            in_if,
  output mctt_pkg::mem_req_t req,
  input  mctt_pkg::entry_t   rd_data,
  input  logic               push_ok,
  output logic               push_v,
  output mctt_pkg::result_t  push_data
);
  import mctt_pkg::*;

  localparam int LIVE = (NUM_CHANNELS < ADDRESSABLE) ? NUM_CHANNELS : ADDRESSABLE;
  localparam logic [CH_FIELD_W-1:0] LAST_IDX = CH_FIELD_W'(LIVE - 1);

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_FLUSH, S_CMD} state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [CH_FIELD_W-1:0] ch_r, ch_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]     tgt_r, tgt_nxt;
  logic                  ok_r, ok_nxt;
  logic [CH_FIELD_W-1:0] idx_r, idx_nxt;
  result_t               pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;

  op_t    in_op;
  logic   in_ok;
  logic   active;
  logic   fire;
  logic   emit;
  entry_t upd;

  assign in_op = op_t'(in_if.op);
  assign in_ok = int'(in_if.channel) < LIVE;
  assign in_if.ready = (state_r == S_IDLE);

  // tick update of the entry under the sweep
  always_comb begin
    active = (rd_data.mode != MODE_IDLE) && !rd_data.pause;
    fire   = active && (rd_data.count == '0);
    emit   = fire && ((rd_data.mode == MODE_WAKE) || (rd_data.mode == MODE_PERIODIC));
    upd    = rd_data;
    if (active && !fire) begin
      upd.count = rd_data.count - COUNT_W'(1);
    end else if (fire && (rd_data.mode == MODE_PERIODIC)) begin
      upd.count = {{(COUNT_W-BYTE_W){1'b0}}, rd_data.period};
    end else if (fire) begin
      upd.mode = MODE_IDLE;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ch_nxt     = ch_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    ok_nxt     = ok_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    req        = '0;
    push_v     = 1'b0;
    push_data  = pend_r;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt  = in_op;
          ch_nxt  = in_if.channel;
          cnt_nxt = in_if.start_count;
          tgt_nxt = in_if.target_id;
          ok_nxt  = in_ok;
          if (in_op == OP_TICK) begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
            idx_nxt     = '0;
            pend_v_nxt  = 1'b0;
            state_nxt   = S_TICK;
          end else if (in_ok || (in_op inside {OP_STOP, OP_CHECK})) begin
            req.rd_en   = 1'b1;
            req.rd_addr = in_if.channel;
            state_nxt   = S_CMD;
          end
        end
      end

      S_TICK: begin
        if (!(emit && pend_v_r && !push_ok)) begin
          if (emit && pend_v_r) begin
            push_v         = 1'b1;
            push_data.last = 1'b0;
          end
          if (active) begin
            req.wr_en   = 1'b1;
            req.wr_addr = idx_r;
            req.wr_data = upd;
          end
          if (emit) begin
            pend_nxt.kind      = (rd_data.mode == MODE_PERIODIC) ? KIND_SIGNAL : KIND_WAKE;
            pend_nxt.channel   = idx_r;
            pend_nxt.target    = rd_data.target;
            pend_nxt.remaining = '0;
            pend_nxt.last      = 1'b0;
            pend_v_nxt         = 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt     = idx_r + CH_FIELD_W'(1);
            req.rd_en   = 1'b1;
            req.rd_addr = idx_r + CH_FIELD_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (push_ok) begin
          push_v         = 1'b1;
          push_data.last = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_CMD: begin
        req.wr_addr = ch_r;
        req.wr_data = rd_data;
        case (op_r)
          OP_START_WAKE: begin
            req.wr_en          = ok_r;
            req.wr_data.mode   = MODE_WAKE;
            req.wr_data.count  = cnt_r;
            req.wr_data.pause  = 1'b0;
            req.wr_data.target = tgt_r;
            state_nxt          = S_IDLE;
          end
          OP_START_PERIODIC: begin
            req.wr_en          = ok_r;
            req.wr_data.mode   = MODE_PERIODIC;
            req.wr_data.count  = {{(COUNT_W-BYTE_W){1'b0}}, cnt_r[BYTE_W-1:0]};
            req.wr_data.pause  = 1'b0;
            req.wr_data.period = cnt_r[BYTE_W-1:0];
            req.wr_data.target = tgt_r;
            state_nxt          = S_IDLE;
          end
          OP_START_COUNTDOWN: begin
            req.wr_en         = ok_r;
            req.wr_data.mode  = MODE_COUNTDOWN;
            req.wr_data.count = cnt_r;
            req.wr_data.pause = 1'b0;
            state_nxt         = S_IDLE;
          end
          OP_PAUSE: begin
            req.wr_en         = ok_r;
            req.wr_data.pause = 1'b1;
            state_nxt         = S_IDLE;
          end
          OP_RESUME: begin
            req.wr_en         = ok_r;
            req.wr_data.pause = 1'b0;
            state_nxt         = S_IDLE;
          end
          OP_STOP, OP_CHECK: begin
            if (push_ok) begin
              push_v              = 1'b1;
              push_data.kind      = KIND_REPLY;
              push_data.channel   = ch_r;
              push_data.target    = '0;
              push_data.remaining = ok_r ? rd_data.count : '0;
              push_data.last      = 1'b1;
              req.wr_en           = ok_r && (op_r == OP_STOP);
              req.wr_data.mode    = MODE_IDLE;
              state_nxt           = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
    end
    op_r   <= op_nxt;
    ch_r   <= ch_nxt;
    cnt_r  <= cnt_nxt;
    tgt_r  <= tgt_nxt;
    ok_r   <= ok_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
  end

endmodule

// File: hdl/multi_channel_tick_timer_bank_core.sv
// an accepted command issues its memory read in the same cycle, unless it is a start,
// pause or resume beyond the bank; a tick sweeps min(NUM_CHANNELS, 8) channels, one
// per cycle unless an event waits on a full result register, bounded by the single read
// port; results sit in an output register, so a new command is taken while one waits
// reset: synchronous active-low, clears control state and the memory valid bits;
// every channel then reads as inactive, unpaused, with zero count, period and target
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_tick_timer_bank_core
// Bank of countdown timer channels with wake, periodic and countdown modes,
// command sequencer over a state memory and a registered result stage.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_bank_core #(
  parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mctt_in_if.sink    in_if,
  mctt_out_if.source out_if
);
  import mctt_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rd_data;
  logic     push_ok;
  logic     push_v;
  result_t  push_data;

  logic     out_valid_r;
  result_t  out_data_r;

  mctt_seq #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .req       (mem_req),
    .rd_data   (mem_rd_data),
    .push_ok   (push_ok),
    .push_v    (push_v),
    .push_data (push_data)
  );

  mctt_mem #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // result register
  assign push_ok = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_v) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (push_v) begin
      out_data_r <= push_data;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_data_r.kind;
  assign out_if.out_channel = out_data_r.channel;
  assign out_if.out_target  = out_data_r.target;
  assign out_if.remaining   = out_data_r.remaining;
  assign out_if.last        = out_data_r.last;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push_v && out_valid_r |-> out_if.ready)
    else $error("result register overwritten while a transaction waits");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.kind == KIND_REPLY) |-> out_if.last)
    else $error("count reply without last flag");

  a_event_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.kind != KIND_REPLY) |-> (out_if.remaining == '0))
    else $error("event carries a nonzero remaining count");

  a_reply_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.kind == KIND_REPLY) |-> (out_if.out_target == '0))
    else $error("count reply carries a target");
`endif

endmodule

// File: verif/multi_channel_tick_timer_bank_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_tick_timer_bank_core_checker
// Passive scoreboard for the timer bank. It keeps its own copy of every
// channel's mode, count, pause flag, period and target. For each accepted
// command it works out the signal, wake and count-reply transactions that
// command causes. Each result transaction is compared in order against
// that list.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_bank_core_checker #(
  parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mctt_in_if   cmd_mon,
  mctt_out_if  res_mon,
  output int   error_count,
  output int   pending_count,
  output int   result_count
);
  import mctt_pkg::*;

  localparam int LIVE = (NUM_CHANNELS < ADDRESSABLE) ? NUM_CHANNELS : ADDRESSABLE;

  mode_t       chan_mode   [LIVE];
  logic [15:0] chan_count  [LIVE];
  logic        chan_paused [LIVE];
  logic [7:0]  chan_period [LIVE];
  logic [7:0]  chan_target [LIVE];

  result_t due_results[$];
  int      errors  = 0;
  int      checked = 0;

  function automatic void clear_bank();
    for (int c = 0; c < LIVE; c++) begin
      chan_mode[c]   = MODE_IDLE;
      chan_count[c]  = '0;
      chan_paused[c] = 1'b0;
      chan_period[c] = '0;
      chan_target[c] = '0;
    end
    due_results.delete();
  endfunction

  // every live channel in ascending order; last goes on the final event
  function automatic void run_tick();
    result_t ev;
    result_t held;
    bit      have;
    have = 1'b0;
    held = '0;
    for (int c = 0; c < LIVE; c++) begin
      if (chan_mode[c] == MODE_IDLE || chan_paused[c]) continue;
      if (chan_count[c] != 16'd0) begin
        chan_count[c] = chan_count[c] - 16'd1;
        continue;
      end
      if (chan_mode[c] == MODE_COUNTDOWN) begin
        chan_mode[c] = MODE_IDLE;
        continue;
      end
      ev = '0;
      ev.channel = 3'(c);
      ev.target  = chan_target[c];
      if (chan_mode[c] == MODE_PERIODIC) begin
        ev.kind = KIND_SIGNAL;
        chan_count[c] = {8'd0, chan_period[c]};
      end else begin
        ev.kind = KIND_WAKE;
        chan_mode[c] = MODE_IDLE;
      end
      if (have) due_results.push_back(held);
      held = ev;
      have = 1'b1;
    end
    if (have) begin
      held.last = 1'b1;
      due_results.push_back(held);
    end
  endfunction

  function automatic void apply_command(op_t op, logic [2:0] ch, logic [15:0] cnt,
                                        logic [7:0] tgt);
    result_t reply;
    bit      hit;
    hit = (int'(ch) < LIVE);
    case (op)
      OP_TICK: run_tick();
      OP_STOP, OP_CHECK: begin
        reply = '0;
        reply.kind    = KIND_REPLY;
        reply.channel = ch;
        reply.last    = 1'b1;
        if (hit) begin
          reply.remaining = chan_count[ch];
          if (op == OP_STOP) chan_mode[ch] = MODE_IDLE;
        end
        due_results.push_back(reply);
      end
      OP_START_WAKE: if (hit) begin
        chan_count[ch]  = cnt;
        chan_paused[ch] = 1'b0;
        chan_target[ch] = tgt;
        chan_mode[ch]   = MODE_WAKE;
      end
      OP_START_PERIODIC: if (hit) begin
        chan_count[ch]  = {8'd0, cnt[7:0]};
        chan_period[ch] = cnt[7:0];
        chan_paused[ch] = 1'b0;
        chan_target[ch] = tgt;
        chan_mode[ch]   = MODE_PERIODIC;
      end
      OP_START_COUNTDOWN: if (hit) begin
        chan_count[ch]  = cnt;
        chan_paused[ch] = 1'b0;
        chan_mode[ch]   = MODE_COUNTDOWN;
      end
      OP_PAUSE:  if (hit) chan_paused[ch] = 1'b1;
      OP_RESUME: if (hit) chan_paused[ch] = 1'b0;
      default: ;
    endcase
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("checker: %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(result_t seen);
    result_t want;
    checked++;
    if (due_results.size() == 0) begin
      flag_error($sformatf("unexpected result kind %0d ch %0d tgt %0d rem %0d last %0d",
                           seen.kind, seen.channel, seen.target, seen.remaining, seen.last));
    end else begin
      want = due_results.pop_front();
      if (seen.kind !== want.kind || seen.channel !== want.channel ||
          seen.target !== want.target || seen.remaining !== want.remaining ||
          seen.last !== want.last)
        flag_error($sformatf({"mismatch expected kind %0d ch %0d tgt %0d rem %0d last %0d,",
                              " actual kind %0d ch %0d tgt %0d rem %0d last %0d"},
                             want.kind, want.channel, want.target, want.remaining, want.last,
                             seen.kind, seen.channel, seen.target, seen.remaining,
                             seen.last));
    end
  endtask

  always @(posedge clk) begin
    result_t seen;
    if (!rst_n) begin
      clear_bank();
    end else begin
      // older results leave before the new command adds its own
      if (res_mon.valid && res_mon.ready) begin
        seen.kind      = kind_t'(res_mon.kind);
        seen.channel   = res_mon.out_channel;
        seen.target    = res_mon.out_target;
        seen.remaining = res_mon.remaining;
        seen.last      = res_mon.last;
        check_result(seen);
      end
      if (cmd_mon.valid && cmd_mon.ready)
        apply_command(op_t'(cmd_mon.op), cmd_mon.channel, cmd_mon.start_count,
                      cmd_mon.target_id);
    end
    error_count   <= errors;
    pending_count <= due_results.size();
    result_count  <= checked;
  end

endmodule

// File: verif/multi_channel_tick_timer_bank_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_tick_timer_bank_core_tb
// Drives the timer bank with a short directed sequence and then random
// command streams weighted towards ticks and short counts. Both handshakes
// stall at random. The checker beside the block predicts and compares every
// result transaction. The top reports a verdict from the checker's error
// count.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_bank_core_tb;
  import mctt_pkg::*;

  localparam int NUM_CH     = NUM_CHANNELS_DEF;
  localparam int QUIET_MAX  = 2000;
  localparam int BLOCKS     = 9;
  localparam int BLOCK_LEN  = 50;

  logic clk;
  logic rst_n;
  int   error_count;
  int   pending_count;
  int   result_count;
  int   quiet_cycles;
  int   cmds_sent;
  int   ticks_sent;
  bit   send_calm;
  bit   recv_calm;

  mctt_in_if  cmd_if ();
  mctt_out_if res_if ();

  multi_channel_tick_timer_bank_core #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (cmd_if),
    .out_if(res_if)
  );

  multi_channel_tick_timer_bank_core_checker #(
    .NUM_CHANNELS(NUM_CH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_mon      (cmd_if),
    .res_mon      (res_if),
    .error_count  (error_count),
    .pending_count(pending_count),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_cmd(op_t op, logic [2:0] ch, logic [15:0] cnt, logic [7:0] tgt);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.op          <= op;
    cmd_if.channel     <= ch;
    cmd_if.start_count <= cnt;
    cmd_if.target_id   <= tgt;
    do @(posedge clk); while (!cmd_if.ready);
    cmds_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  // hold off until every outstanding result has been taken
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic random_cmd();
    int          pick;
    op_t         op;
    logic [15:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_TICK;
    else if (pick < 47) op = OP_START_WAKE;
    else if (pick < 59) op = OP_START_PERIODIC;
    else if (pick < 69) op = OP_START_COUNTDOWN;
    else if (pick < 76) op = OP_STOP;
    else if (pick < 83) op = OP_PAUSE;
    else if (pick < 89) op = OP_RESUME;
    else                op = OP_CHECK;
    if ($urandom_range(0, 9) == 0)
      cnt = 16'($urandom);
    else if (op == OP_START_PERIODIC)
      cnt = {8'($urandom), 8'($urandom_range(0, 4))};
    else
      cnt = 16'($urandom_range(0, 6));
    send_cmd(op, 3'($urandom_range(0, 7)), cnt, 8'($urandom));
  endtask

  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_MAX);
        $display("multi_channel_tick_timer_bank_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.op          = OP_TICK;
    cmd_if.channel     = '0;
    cmd_if.start_count = '0;
    cmd_if.target_id   = '0;
    cmds_sent          = 0;
    ticks_sent         = 0;
    send_calm          = 1'b0;
    recv_calm          = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, extremes, pause, period zero, full bank
    send_cmd(OP_CHECK,           3'd0, 16'h0000, 8'h00);
    send_cmd(OP_STOP,            3'd7, 16'h0000, 8'h00);
    send_cmd(OP_START_WAKE,      3'd0, 16'h0000, 8'hFF);
    send_cmd(OP_START_PERIODIC,  3'd1, 16'hFF00, 8'hAA);
    send_cmd(OP_START_COUNTDOWN, 3'd2, 16'hFFFF, 8'h55);
    send_cmd(OP_TICK,            3'd5, 16'hFFFF, 8'hFF);
    send_cmd(OP_CHECK,           3'd2, 16'hFFFF, 8'hFF);
    send_cmd(OP_PAUSE,           3'd1, 16'h0000, 8'h00);
    send_cmd(OP_TICK,            3'd0, 16'h0000, 8'h00);
    send_cmd(OP_PAUSE,           3'd6, 16'h1234, 8'h00);
    send_cmd(OP_RESUME,          3'd6, 16'h0000, 8'h00);
    send_cmd(OP_RESUME,          3'd1, 16'h0000, 8'h00);
    send_cmd(OP_TICK,            3'd0, 16'h0000, 8'h00);
    send_cmd(OP_STOP,            3'd2, 16'h0000, 8'h00);
    send_cmd(OP_START_PERIODIC,  3'd3, 16'h01FF, 8'h00);
    send_cmd(OP_PAUSE,           3'd3, 16'h0000, 8'h00);
    send_cmd(OP_START_WAKE,      3'd3, 16'h0001, 8'h7E);
    send_cmd(OP_START_COUNTDOWN, 3'd4, 16'h0000, 8'h00);
    send_cmd(OP_TICK,            3'd0, 16'h0000, 8'h00);
    for (int c = 0; c < 8; c++)
      send_cmd(OP_START_WAKE, 3'(c), 16'h0000, 8'(c * 37 + 1));
    send_cmd(OP_TICK,            3'd0, 16'h0000, 8'h00);

    for (int b = 0; b < BLOCKS; b++) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < BLOCK_LEN; i++) random_cmd();
      if (b == BLOCKS / 2) settle();
    end

    settle();
    repeat (20) @(posedge clk);

    $display("summary: %0d commands including %0d ticks, %0d result transactions checked",
             cmds_sent, ticks_sent, result_count);
    if (error_count == 0)
      $display("multi_channel_tick_timer_bank_core_tb: done, clean");
    else
      $display("multi_channel_tick_timer_bank_core_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
hdl/mctt_pkg.sv
hdl/mctt_if.sv
hdl/mctt_mem.sv
hdl/mctt_seq.sv
hdl/multi_channel_tick_timer_bank_core.sv
verif/multi_channel_tick_timer_bank_core_checker.sv
verif/multi_channel_tick_timer_bank_core_tb.sv
